// ===== sv/kars_pkg.sv =====
package kars_pkg;

    // Slot table size and the derived index width.
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // At most this many repeat results are reported for one tick.
    localparam int MAX_RESULTS = 8;
    localparam int FIRE_CW     = $clog2(MAX_RESULTS + 1);

    localparam int KEY_W    = 10;
    localparam int RATE_W   = 10;
    localparam int DELAY_W  = 14;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = 10;
    localparam int TMO_W    = 15;
    localparam int CLAMP_W  = 14;
    localparam int CFG_W    = 14;
    localparam int CFG_IW   = 1;

    localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(25);
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = DELAY_W'(600);
    localparam logic [PERIOD_W-1:0] MS_PER_SEC   = PERIOD_W'(1000);
    // ceil(1000 / 25), the period that matches the reset rate.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(40);
    localparam logic [CLAMP_W-1:0]  TIMEOUT_MAX  = CLAMP_W'(16383);
    // All ones, which reads as -1 in the signed timeout field.
    localparam logic signed [TMO_W-1:0] TIMEOUT_NONE = '1;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_TICK    = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_QUERY   = 3'd4
    } op_t;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_FIRE    = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [CFG_IW-1:0] REG_RATE  = 1'd0;
    localparam logic [CFG_IW-1:0] REG_DELAY = 1'd1;

    typedef struct packed {
        logic start;   // request accepted, latch it and restart the scan
        logic step;    // process the slot under the scan index
        logic finish;  // emit the closing result and commit a press
    } kars_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic pend_valid;
        logic scan_last;
        logic out_free;
        logic div_busy;
    } kars_sts_t;

endpackage

// ===== sv/kars_div.sv =====
module kars_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [kars_pkg::RATE_W-1:0]         divisor,
    output logic                                busy,
    output logic [kars_pkg::PERIOD_W-1:0]       period
);

    logic                              busy_reg, busy_next;
    logic [kars_pkg::PERIOD_W-1:0]     period_reg, period_next;
    logic [kars_pkg::DIV_CW-1:0]       cnt_reg;
    logic [kars_pkg::PERIOD_W-1:0]     num_reg;
    logic [kars_pkg::RATE_W-1:0]       rem_reg, rem_next;
    logic [kars_pkg::PERIOD_W-1:0]     quo_reg, quo_next;
    logic [kars_pkg::RATE_W-1:0]       div_reg;
    logic [kars_pkg::RATE_W:0]         rem_sh;
    logic                              ge;

    // One restoring step: shift in the next numerator bit, subtract if it fits.
    always_comb begin
        rem_sh   = {rem_reg, num_reg[kars_pkg::PERIOD_W-1]};
        ge       = rem_sh >= {1'b0, div_reg};
        rem_next = ge ? kars_pkg::RATE_W'(rem_sh - {1'b0, div_reg})
                      : rem_sh[kars_pkg::RATE_W-1:0];
        quo_next = {quo_reg[kars_pkg::PERIOD_W-2:0], ge};
        busy_next   = busy_reg;
        period_next = period_reg;
        if (start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == kars_pkg::DIV_CW'(kars_pkg::DIV_STEPS - 1)) begin
            busy_next = 1'b0;
            if (div_reg == '0) begin
                period_next = kars_pkg::MS_PER_SEC;
            end else begin
                period_next = quo_next + kars_pkg::PERIOD_W'(rem_next != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            period_reg <= kars_pkg::PERIOD_RESET;
        end else begin
            busy_reg   <= busy_next;
            period_reg <= period_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            num_reg <= kars_pkg::MS_PER_SEC;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[kars_pkg::PERIOD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg + kars_pkg::DIV_CW'(1);
        end
    end

    assign busy   = busy_reg;
    assign period = period_reg;

endmodule

// ===== sv/kars_dpath.sv =====
module kars_dpath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  kars_pkg::kars_cmd_t                    cmd,
    output kars_pkg::kars_sts_t                    sts,
    input  logic [2:0]                             in_op,
    input  logic [kars_pkg::KEY_W-1:0]             in_key,
    input  logic                                   in_rep,
    input  logic                                   cfg_we,
    input  logic [kars_pkg::CFG_IW-1:0]            cfg_index,
    input  logic [kars_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                   m_tready,
    output logic                                   out_valid,
    output logic [1:0]                             out_kind,
    output logic [kars_pkg::KEY_W-1:0]             out_key,
    output logic                                   out_found,
    output logic signed [kars_pkg::TMO_W-1:0]      out_tmo,
    output logic                                   out_last
);

    localparam int N  = kars_pkg::SLOT_COUNT;
    localparam int IW = kars_pkg::SLOT_IW;

    // Configuration.
    logic [kars_pkg::RATE_W-1:0]     rate_reg;
    logic [kars_pkg::DELAY_W-1:0]    delay_reg;
    logic                            div_start, div_busy;
    logic [kars_pkg::PERIOD_W-1:0]   period;

    // Slot table and clock.
    logic [N-1:0]                    active_reg;
    logic [kars_pkg::KEY_W-1:0]      slot_key_reg [N];
    logic [kars_pkg::TIME_W-1:0]     slot_due_reg [N];
    logic [kars_pkg::TIME_W-1:0]     time_now_reg;

    // Request being worked on and scan state.
    logic [2:0]                      op_reg;
    logic [kars_pkg::KEY_W-1:0]      key_reg;
    logic                            rep_reg;
    logic [IW-1:0]                   idx_reg;
    logic                            hit_reg;
    logic [IW-1:0]                   hit_idx_reg;
    logic                            free_found_reg;
    logic [IW-1:0]                   free_idx_reg;
    logic                            any_reg;
    logic [kars_pkg::CLAMP_W-1:0]    best_reg;
    logic [kars_pkg::FIRE_CW-1:0]    fire_cnt_reg;
    logic                            pend_valid_reg;
    logic [kars_pkg::KEY_W-1:0]      pend_key_reg;

    // Result register.
    logic                            out_valid_reg;
    logic [1:0]                      out_kind_reg, fin_kind;
    logic [kars_pkg::KEY_W-1:0]      out_key_reg, fin_key;
    logic                            out_found_reg, fin_found;
    logic signed [kars_pkg::TMO_W-1:0] out_tmo_reg, fin_tmo;
    logic                            out_last_reg;

    logic                            is_press, is_release, is_tick, is_query;
    logic                            cur_active, key_hit, fire, report, armed;
    logic [kars_pkg::KEY_W-1:0]      cur_key;
    logic [kars_pkg::TIME_W-1:0]     cur_due, late, left;
    logic [kars_pkg::CLAMP_W-1:0]    left_clamp;
    logic [IW-1:0]                   target;
    logic                            out_free, has_final, fire_load, out_load;

    assign div_start = cfg_we && cfg_index == kars_pkg::REG_RATE;

    kars_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (cfg_wdata[kars_pkg::RATE_W-1:0]),
        .busy    (div_busy),
        .period  (period)
    );

    assign is_press   = op_reg == kars_pkg::OP_PRESS;
    assign is_release = op_reg == kars_pkg::OP_RELEASE;
    assign is_tick    = op_reg == kars_pkg::OP_TICK;
    assign is_query   = op_reg == kars_pkg::OP_QUERY;

    always_comb begin
        cur_active = active_reg[idx_reg];
        cur_key    = slot_key_reg[idx_reg];
        cur_due    = slot_due_reg[idx_reg];
        key_hit    = cur_active && cur_key == key_reg;
        late       = time_now_reg - cur_due;
        left       = cur_due - time_now_reg;
        fire       = cur_active && !late[kars_pkg::TIME_W-1];
        report     = fire && fire_cnt_reg < kars_pkg::FIRE_CW'(kars_pkg::MAX_RESULTS);
        if (left[kars_pkg::TIME_W-1]) begin
            left_clamp = '0;
        end else if (|left[kars_pkg::TIME_W-2:kars_pkg::CLAMP_W]) begin
            left_clamp = kars_pkg::TIMEOUT_MAX;
        end else begin
            left_clamp = left[kars_pkg::CLAMP_W-1:0];
        end
        armed  = rep_reg && rate_reg != '0 && (hit_reg || free_found_reg);
        target = hit_reg ? hit_idx_reg : free_idx_reg;
    end

    // Closing result of the request.
    always_comb begin
        fin_kind  = kars_pkg::KIND_ACK;
        fin_key   = '0;
        fin_found = 1'b0;
        fin_tmo   = '0;
        unique case (op_reg)
            kars_pkg::OP_PRESS: begin
                fin_key   = key_reg;
                fin_found = armed;
            end
            kars_pkg::OP_RELEASE: begin
                fin_key   = key_reg;
                fin_found = hit_reg;
            end
            kars_pkg::OP_TICK: begin
                fin_kind = kars_pkg::KIND_FIRE;
                fin_key  = pend_key_reg;
            end
            kars_pkg::OP_QUERY: begin
                fin_kind = kars_pkg::KIND_TIMEOUT;
                fin_tmo  = any_reg ? kars_pkg::TMO_W'({1'b0, best_reg})
                                   : kars_pkg::TIMEOUT_NONE;
            end
            default: begin
            end
        endcase
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign has_final = !is_tick || pend_valid_reg;
    // A new firing slot pushes out the one held before it.
    assign fire_load = cmd.step && is_tick && report && pend_valid_reg;
    assign out_load  = fire_load || (cmd.finish && has_final);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg       <= kars_pkg::RATE_RESET;
            delay_reg      <= kars_pkg::DELAY_RESET;
            time_now_reg   <= '0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    kars_pkg::REG_RATE:  rate_reg  <= cfg_wdata[kars_pkg::RATE_W-1:0];
                    kars_pkg::REG_DELAY: delay_reg <= cfg_wdata[kars_pkg::DELAY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.start) begin
                fire_cnt_reg   <= '0;
                pend_valid_reg <= 1'b0;
                if (in_op == kars_pkg::OP_TICK) begin
                    time_now_reg <= time_now_reg + kars_pkg::TIME_W'(1);
                end
                if (in_op == kars_pkg::OP_CLEAR) begin
                    active_reg <= '0;
                end
            end else if (cmd.step) begin
                if (is_release && key_hit && !hit_reg) begin
                    active_reg[idx_reg] <= 1'b0;
                end
                if (is_tick && report) begin
                    pend_valid_reg <= 1'b1;
                    fire_cnt_reg   <= fire_cnt_reg + kars_pkg::FIRE_CW'(1);
                end
            end else if (cmd.finish) begin
                pend_valid_reg <= 1'b0;
                if (is_press && armed) begin
                    active_reg[target] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg         <= in_op;
            key_reg        <= in_key;
            rep_reg        <= in_rep;
            idx_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            any_reg        <= 1'b0;
        end else if (cmd.step) begin
            idx_reg <= idx_reg + IW'(1);
            if ((is_press || is_release) && key_hit && !hit_reg) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if (is_press && !cur_active && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (is_query && cur_active && (!any_reg || left_clamp < best_reg)) begin
                any_reg  <= 1'b1;
                best_reg <= left_clamp;
            end
            if (is_tick && fire) begin
                slot_due_reg[idx_reg] <= time_now_reg + kars_pkg::TIME_W'(period);
            end
            if (is_tick && report) begin
                pend_key_reg <= cur_key;
            end
        end else if (cmd.finish && is_press && armed) begin
            slot_key_reg[target] <= key_reg;
            slot_due_reg[target] <= time_now_reg + kars_pkg::TIME_W'(delay_reg);
        end
        if (fire_load) begin
            out_kind_reg  <= kars_pkg::KIND_FIRE;
            out_key_reg   <= pend_key_reg;
            out_found_reg <= 1'b0;
            out_tmo_reg   <= '0;
            out_last_reg  <= 1'b0;
        end else if (cmd.finish && has_final) begin
            out_kind_reg  <= fin_kind;
            out_key_reg   <= fin_key;
            out_found_reg <= fin_found;
            out_tmo_reg   <= fin_tmo;
            out_last_reg  <= 1'b1;
        end
    end

    assign sts.is_tick    = is_tick;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.scan_last  = idx_reg == IW'(N - 1);
    assign sts.out_free   = out_free;
    assign sts.div_busy   = div_busy;

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_key   = out_key_reg;
    assign out_found = out_found_reg;
    assign out_tmo   = out_tmo_reg;
    assign out_last  = out_last_reg;

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // The report count of a tick never passes the result limit.
    a_fire_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= kars_pkg::FIRE_CW'(kars_pkg::MAX_RESULTS))
        else $error("fire count above limit");

    // No held repeat survives the end of a request.
    a_pend_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> !pend_valid_reg)
        else $error("pending repeat left after finish");

endmodule

// ===== sv/kars_ctrl.sv =====
module kars_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  kars_pkg::kars_sts_t    sts,
    output kars_pkg::kars_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = !sts.div_busy;
                cmd.start = s_tvalid && !sts.div_busy;
                if (cmd.start) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // A firing slot may need the result register for the repeat held before it.
                cmd.step = !(sts.is_tick && sts.pend_valid && !sts.out_free);
                if (cmd.step && sts.scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                cmd.finish = sts.out_free;
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The closing result waits while the result register is still held.
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !sts.out_free) |=> state_reg == ST_DONE)
        else $error("left done state with output blocked");

    // A scan step never stalls a tick into dropping a held repeat.
    a_step_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && sts.is_tick && sts.pend_valid) |-> sts.out_free)
        else $error("tick step without room for held repeat");

endmodule

// ===== sv/key_autorepeat_slot_engine.sv =====
// A request is accepted in the idle state; the scan then steps one slot per cycle, but a
//   tick stalls its step while a held repeat finds the result register full. The closing
//   result is registered in the done state once that register is free. A new request is
//   taken only after the closing result of the last one. A write of the rate register
//   occupies the period divider, during which no request is taken.
// Reset (aresetn low, synchronous): all slots free, time zero, rate 25, delay 600 ms.
module key_autorepeat_slot_engine (
    input  logic                                aclk,
    input  logic                                aresetn,

    // Request channel.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // key_code[9:0], repeatable[10]
    input  logic [2:0]                          s_tuser,  // op[2:0]

    // Result channel.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,  // key_code_res[9:0],
                                                          // slot_found[10], timeout_ms[25:11]
    output logic [1:0]                          m_tuser,  // kind[1:0]
    output logic                                m_tlast,

    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [kars_pkg::CFG_IW-1:0]         cfg_index,
    input  logic [kars_pkg::CFG_W-1:0]          cfg_wdata
);

    kars_pkg::kars_cmd_t                 cmd;
    kars_pkg::kars_sts_t                 sts;
    logic [kars_pkg::KEY_W-1:0]          out_key;
    logic                                out_found;
    logic signed [kars_pkg::TMO_W-1:0]   out_tmo;

    // The controller sequences each request: accept, one step per slot, then the
    // closing result. A tick reports each firing slot as the next one is found, so
    // the last repeat of a tick can carry tlast.
    kars_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the slot table, the millisecond clock, the configuration,
    // the repeat period divider and the result register that parts the two sides.
    kars_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser),
        .in_key    (s_tdata[kars_pkg::KEY_W-1:0]),
        .in_rep    (s_tdata[kars_pkg::KEY_W]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_key   (out_key),
        .out_found (out_found),
        .out_tmo   (out_tmo),
        .out_last  (m_tlast)
    );

    // Fields are packed from bit 0 upward, zero filled to a whole number of bytes.
    assign m_tdata = {6'b0, out_tmo, out_found, out_key};

endmodule

// ===== dv/tb_key_autorepeat_slot_engine.sv =====
module tb_key_autorepeat_slot_engine;

    // Timing of the bench. The settle time before a register write covers a tick that
    // is still scanning and gives no result, with margin.
    localparam int HALF_PERIOD      = 10;
    localparam int RESET_CYCLES     = 5;
    localparam int SETTLE_CYCLES    = 24;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int PHASE_ITEMS      = 52;
    localparam int POOL_SIZE        = 8;
    localparam int IDLE_PERCENT     = 36;

    // Op codes above the last defined one. The block must acknowledge them and
    // leave its state alone.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // One result of the block, with its fields at their port widths.
    typedef struct packed {
        logic [1:0]                        kind;
        logic [kars_pkg::KEY_W-1:0]        key;
        logic                              found;
        logic signed [kars_pkg::TMO_W-1:0] tmo;
        logic                              last;
    } repeat_result_t;

    // The scoreboard mirrors the slot table, the millisecond counter and both
    // registers. Every accepted request is played against that copy, and the
    // results it must cause wait in order until the block delivers them.
    class typematic_scoreboard;
        logic [kars_pkg::RATE_W-1:0]  rate;
        logic [kars_pkg::DELAY_W-1:0] delay_ms;
        logic                         slot_live [kars_pkg::SLOT_COUNT];
        logic [kars_pkg::KEY_W-1:0]   slot_code [kars_pkg::SLOT_COUNT];
        logic [kars_pkg::TIME_W-1:0]  slot_due [kars_pkg::SLOT_COUNT];
        logic [kars_pkg::TIME_W-1:0]  now_ms;
        repeat_result_t               awaited [$];
        int                           mismatches;
        int                           requests;
        int                           checked;
        int                           fires;
        int                           reg_writes;

        function new();
            rate     = kars_pkg::RATE_RESET;
            delay_ms = kars_pkg::DELAY_RESET;
            now_ms   = '0;
            foreach (slot_live[i]) begin
                slot_live[i] = 1'b0;
                slot_code[i] = '0;
                slot_due[i]  = '0;
            end
            mismatches = 0;
            requests   = 0;
            checked    = 0;
            fires      = 0;
            reg_writes = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_register(logic [kars_pkg::CFG_IW-1:0] idx,
                                   logic [kars_pkg::CFG_W-1:0] value);
            if (idx == kars_pkg::REG_RATE) begin
                rate = value[kars_pkg::RATE_W-1:0];
            end else begin
                delay_ms = value[kars_pkg::DELAY_W-1:0];
            end
            reg_writes++;
        endfunction

        function void note_request(logic [2:0] op, logic [kars_pkg::KEY_W-1:0] key,
                                   logic rep);
            int                          hit;
            int                          spare;
            logic                        found;
            logic                        any;
            logic [kars_pkg::TIME_W-1:0] period;
            logic [kars_pkg::TIME_W-1:0] gap;
            logic [kars_pkg::TIME_W-1:0] best;
            repeat_result_t              r;
            repeat_result_t              fired [$];

            requests++;
            r      = '0;
            r.kind = kars_pkg::KIND_ACK;
            r.last = 1'b1;
            case (op)
                kars_pkg::OP_PRESS: begin
                    // Reuse the slot that already holds the key, else the lowest free one.
                    hit = -1;
                    if (rep && rate != '0) begin
                        spare = -1;
                        for (int i = 0; i < kars_pkg::SLOT_COUNT; i++) begin
                            if (slot_live[i] && slot_code[i] == key) begin
                                hit = i;
                                break;
                            end
                            if (!slot_live[i] && spare < 0) spare = i;
                        end
                        if (hit < 0) hit = spare;
                        if (hit >= 0) begin
                            slot_live[hit] = 1'b1;
                            slot_code[hit] = key;
                            slot_due[hit]  = now_ms + kars_pkg::TIME_W'(delay_ms);
                        end
                    end
                    r.key   = key;
                    r.found = (hit >= 0);
                    awaited.push_back(r);
                end
                kars_pkg::OP_RELEASE: begin
                    found = 1'b0;
                    for (int i = 0; i < kars_pkg::SLOT_COUNT; i++) begin
                        if (slot_live[i] && slot_code[i] == key) begin
                            slot_live[i] = 1'b0;
                            slot_code[i] = '0;
                            slot_due[i]  = '0;
                            found        = 1'b1;
                            break;
                        end
                    end
                    r.key   = key;
                    r.found = found;
                    awaited.push_back(r);
                end
                kars_pkg::OP_TICK: begin
                    // The repeat period is ceil(1000 / rate), or a full second at rate zero.
                    period = (rate != '0)
                           ? (kars_pkg::TIME_W'(kars_pkg::MS_PER_SEC)
                              + kars_pkg::TIME_W'(rate) - 1) / kars_pkg::TIME_W'(rate)
                           : kars_pkg::TIME_W'(kars_pkg::MS_PER_SEC);
                    now_ms++;
                    for (int i = 0; i < kars_pkg::SLOT_COUNT; i++) begin
                        if (!slot_live[i]) continue;
                        gap = now_ms - slot_due[i];
                        if (gap[kars_pkg::TIME_W-1]) continue;
                        if (fired.size() < kars_pkg::MAX_RESULTS) begin
                            r.kind  = kars_pkg::KIND_FIRE;
                            r.key   = slot_code[i];
                            r.found = 1'b0;
                            r.last  = 1'b0;
                            fired.push_back(r);
                        end
                        slot_due[i] = now_ms + period;
                    end
                    if (fired.size() > 0) begin
                        r      = fired.pop_back();
                        r.last = 1'b1;
                        fired.push_back(r);
                    end
                    fires += fired.size();
                    foreach (fired[i]) awaited.push_back(fired[i]);
                end
                kars_pkg::OP_CLEAR: begin
                    foreach (slot_live[i]) begin
                        slot_live[i] = 1'b0;
                        slot_code[i] = '0;
                        slot_due[i]  = '0;
                    end
                    awaited.push_back(r);
                end
                kars_pkg::OP_QUERY: begin
                    any  = 1'b0;
                    best = '0;
                    for (int i = 0; i < kars_pkg::SLOT_COUNT; i++) begin
                        if (!slot_live[i]) continue;
                        gap = slot_due[i] - now_ms;
                        if (gap[kars_pkg::TIME_W-1]) begin
                            gap = '0;
                        end else if (gap > kars_pkg::TIME_W'(kars_pkg::TIMEOUT_MAX)) begin
                            gap = kars_pkg::TIME_W'(kars_pkg::TIMEOUT_MAX);
                        end
                        if (!any || gap < best) begin
                            best = gap;
                            any  = 1'b1;
                        end
                    end
                    r.kind = kars_pkg::KIND_TIMEOUT;
                    r.tmo  = any ? kars_pkg::TMO_W'(best) : kars_pkg::TIMEOUT_NONE;
                    awaited.push_back(r);
                end
                default: begin
                    awaited.push_back(r);
                end
            endcase
        endfunction

        function void compare(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(repeat_result_t got);
            repeat_result_t want;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: kind %0d key %0d", got.kind, got.key);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            checked++;
            compare("kind", want.kind, got.kind);
            compare("key_code_res", want.key, got.key);
            compare("slot_found", want.found, got.found);
            compare("timeout_ms", int'(want.tmo), int'(got.tmo));
            compare("last", want.last, got.last);
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [15:0]                   s_tdata;     // key_code[9:0], repeatable[10]
    logic [2:0]                    s_tuser;     // op[2:0]
    logic                          m_tvalid;
    logic                          m_tready;
    logic [31:0]                   m_tdata;     // key_code_res[9:0], slot_found[10],
                                                // timeout_ms[25:11]
    logic [1:0]                    m_tuser;     // kind[1:0]
    logic                          m_tlast;
    logic                          cfg_we;
    logic [kars_pkg::CFG_IW-1:0]   cfg_index;
    logic [kars_pkg::CFG_W-1:0]    cfg_wdata;

    typematic_scoreboard sb;

    // While no_idle is set neither side inserts random gaps. A raised
    // sink_hold_req asks the result side for one long hold-off.
    bit                            no_idle = 1'b0;
    bit                            sink_hold_req = 1'b0;
    int unsigned                   cycle_count = 0;
    logic [kars_pkg::KEY_W-1:0]    key_pool [POOL_SIZE];

    key_autorepeat_slot_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Watchdog. The limit is many times the slowest legal run, which includes
    // the long hold-off and every tick returning a full set of fires.
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side. A result is taken at an edge where m_tvalid and m_tready
    // were both high; the values read right after the edge are the ones the
    // edge saw. m_tready for the next cycle is then chosen: held low during a
    // requested hold-off, otherwise low at random about a third of the time.
    initial begin
        int             hold_left;
        repeat_result_t got;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.key   = m_tdata[9:0];
                got.found = m_tdata[10];
                got.tmo   = m_tdata[25:11];
                got.last  = m_tlast;
                sb.check_result(got);
            end
            if (sink_hold_req) begin
                hold_left     = SINK_HOLD_CYCLES;
                sink_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one request, with random idle cycles ahead of it, and holds it
    // until the block takes it. The scoreboard learns of it at that edge.
    task automatic send_request(logic [2:0] op, logic [kars_pkg::KEY_W-1:0] key, logic rep);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rep, key};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(op, key, rep);
    endtask

    // Stops offering and waits until every awaited result is in. With settle
    // set it also waits out a tick that may still be scanning with no result.
    task automatic wait_drained(bit settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        if (settle) repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers on an idle block: the delay first, then the rate,
    // since a rate write keeps the period divider busy for a while.
    task automatic load_settings(int rate, int delay);
        wait_drained(1'b1);
        cfg_we    <= 1'b1;
        cfg_index <= kars_pkg::REG_DELAY;
        cfg_wdata <= kars_pkg::CFG_W'(delay);
        @(posedge aclk);
        sb.set_register(kars_pkg::REG_DELAY, kars_pkg::CFG_W'(delay));
        cfg_index <= kars_pkg::REG_RATE;
        cfg_wdata <= kars_pkg::CFG_W'(rate);
        @(posedge aclk);
        sb.set_register(kars_pkg::REG_RATE, kars_pkg::CFG_W'(rate));
        cfg_we    <= 1'b0;
    endtask

    // Random traffic looks like real typing: mostly presses, releases and
    // ticks on a small set of keys, so slots are reused, freed and fill up,
    // with stray keys, queries, clears and unused op codes mixed in.
    task automatic random_request();
        int                         pick;
        logic [2:0]                 op;
        logic [kars_pkg::KEY_W-1:0] key;
        logic                       rep;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 75) begin
            key = key_pool[$urandom_range(POOL_SIZE - 1)];
        end else begin
            key = kars_pkg::KEY_W'($urandom_range(767));
        end
        rep = ($urandom_range(99) < 85);
        if (pick < 28) begin
            op = kars_pkg::OP_PRESS;
        end else if (pick < 42) begin
            op = kars_pkg::OP_RELEASE;
        end else if (pick < 88) begin
            op = kars_pkg::OP_TICK;
        end else if (pick < 94) begin
            op = kars_pkg::OP_QUERY;
        end else if (pick < 97) begin
            op = kars_pkg::OP_CLEAR;
        end else begin
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        // Now and then the sender pauses until every awaited result is in.
        if ($urandom_range(199) == 0) wait_drained(1'b0);
        send_request(op, key, rep);
    endtask

    // One random phase under one register setting. With squeeze set, a few
    // keys are armed and then the result side holds off for a long stretch
    // while ticks keep coming, so the block backs up and stalls its input.
    task automatic run_phase(int rate, int delay, bit burst, bit squeeze);
        load_settings(rate, delay);
        foreach (key_pool[i]) key_pool[i] = kars_pkg::KEY_W'($urandom_range(767));
        no_idle = burst;
        if (squeeze) begin
            for (int i = 0; i < 4; i++) send_request(kars_pkg::OP_PRESS, key_pool[i], 1'b1);
            sink_hold_req = 1'b1;
        end
        for (int i = 0; i < PHASE_ITEMS; i++) random_request();
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: an empty table answers -1, a key that may not repeat
        // arms nothing, a second press of a key reuses its slot, a release
        // of a key that is not held finds nothing, and unused op codes are
        // only acknowledged.
        send_request(kars_pkg::OP_QUERY, '0, 1'b0);
        send_request(kars_pkg::OP_PRESS, kars_pkg::KEY_W'(0), 1'b1);
        send_request(kars_pkg::OP_PRESS, kars_pkg::KEY_W'(767), 1'b0);
        send_request(kars_pkg::OP_PRESS, kars_pkg::KEY_W'(767), 1'b1);
        send_request(kars_pkg::OP_PRESS, kars_pkg::KEY_W'(767), 1'b1);
        send_request(kars_pkg::OP_QUERY, '0, 1'b0);
        send_request(kars_pkg::OP_RELEASE, kars_pkg::KEY_W'(767), 1'b0);
        send_request(kars_pkg::OP_RELEASE, kars_pkg::KEY_W'(767), 1'b0);
        send_request(OP_SPARE_LO, kars_pkg::KEY_W'(767), 1'b1);
        send_request(OP_SPARE_HI, kars_pkg::KEY_W'(767), 1'b1);
        send_request(kars_pkg::OP_CLEAR, '0, 1'b0);
        send_request(kars_pkg::OP_QUERY, '0, 1'b0);

        // Fastest rate and no delay: fill all slots, try one more, then a
        // single tick makes every slot fire at once.
        load_settings(1000, 0);
        for (int i = 0; i < kars_pkg::SLOT_COUNT; i++) begin
            send_request(kars_pkg::OP_PRESS, kars_pkg::KEY_W'(1) << i, 1'b1);
        end
        send_request(kars_pkg::OP_PRESS, kars_pkg::KEY_W'(256), 1'b1);
        send_request(kars_pkg::OP_QUERY, '0, 1'b0);
        send_request(kars_pkg::OP_TICK, '0, 1'b0);
        send_request(kars_pkg::OP_RELEASE, kars_pkg::KEY_W'(512), 1'b1);

        // Random phases across the register range: rate zero, the slowest
        // and fastest rates, a long delay, and ordinary settings.
        run_phase(1000, 0, 1'b0, 1'b1);
        run_phase(0, 5, 1'b0, 1'b0);
        run_phase(1, 3, 1'b0, 1'b0);
        run_phase($urandom_range(2, 999), 10000, 1'b0, 1'b0);
        run_phase($urandom_range(1, 1000), $urandom_range(30), 1'b1, 1'b0);
        run_phase($urandom_range(1, 1000), $urandom_range(60), 1'b0, 1'b0);
        run_phase(7, 12, 1'b0, 1'b0);

        wait_drained(1'b1);
        $display("Covered %0d requests under %0d register writes, with slot reuse and a full table.",
                 sb.requests, sb.reg_writes);
        $display("Checked %0d results, %0d of them repeat fires.", sb.checked, sb.fires);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== key_autorepeat_slot_engine.f =====
sv/kars_pkg.sv
sv/kars_div.sv
sv/kars_dpath.sv
sv/kars_ctrl.sv
sv/key_autorepeat_slot_engine.sv
dv/tb_key_autorepeat_slot_engine.sv
